>>> rtl/core/tcprcw_pkg.sv
package tcprcw_pkg;

  // Congestion control phase, as reported in the result word
  typedef enum logic [1:0] {
    PH_SLOW    = 2'd0,
    PH_AVOID   = 2'd1,
    PH_RECOVER = 2'd2
  } phase_t;

  // Event kinds carried in s_tuser
  localparam logic [1:0] KIND_NEW_ACK = 2'd0;
  localparam logic [1:0] KIND_DUP_ACK = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;

  // Field widths of the stream words
  localparam int unsigned LOSS_W     = 16;
  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned DUP_W      = 8;
  localparam int unsigned DUP_THR_W  = 4;

  // Window growth after entering fast recovery
  localparam int unsigned RECOVERY_INFLATE = 3;
  localparam logic [DUP_THR_W-1:0] DUP_THR_RESET = 4'd3;

endpackage

>>> rtl/core/tcp_reno_congestion_window_core.sv
// Reno congestion window tracker. Each event word on the slave stream (kind in
// s_tuser: new ACK, duplicate ACK or timeout; signed loss count in s_tdata)
// updates the phase, window, threshold and duplicate count in the cycle it is
// accepted, and one result word (window, threshold, phase) is registered for
// the master stream. One event is taken every cycle: the whole update is a single
// add, shift and compare ahead of the output register, and a one-word skid stage
// takes one more event while a result waits downstream, so s_tready drops only
// once both the output and the skid word are held. The user must write the
// duplicate-ACK trigger over the cfg port while the block idles; nothing checks it.
module tcp_reno_congestion_window_core
  import tcprcw_pkg::*;
#(
  parameter int unsigned INITIAL_THRESHOLD = 64,
  parameter int unsigned WINDOW_WIDTH      = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  // event words
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [LOSS_W-1:0]          s_tdata,   // [15:0] loss_count (signed)
  input  logic [1:0]                 s_tuser,   // [1:0] kind
  // result words
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // [31:0] window, [63:32] threshold,
                                                // [65:64] phase, [71:66] zero
  // duplicate-ACK trigger register
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [DUP_THR_W-1:0]       cfg_data   // [3:0] dup_ack_threshold
);

  localparam longint unsigned WinMaxL = (64'd1 << WINDOW_WIDTH) - 64'd1;
  localparam longint unsigned InitThrL =
    (INITIAL_THRESHOLD > WinMaxL) ? WinMaxL : longint'(INITIAL_THRESHOLD);
  localparam logic [WINDOW_WIDTH-1:0] WinMax  = {WINDOW_WIDTH{1'b1}};
  localparam logic [WINDOW_WIDTH-1:0] InitThr = WINDOW_WIDTH'(InitThrL);
  localparam logic [WINDOW_WIDTH-1:0] WinOne  = WINDOW_WIDTH'(1);
  localparam logic [DUP_W-1:0]        DupMax  = {DUP_W{1'b1}};

  phase_t                  phase, phase_next;
  logic [WINDOW_WIDTH-1:0] window, window_next;
  logic [WINDOW_WIDTH-1:0] threshold, threshold_next;
  logic [DUP_W-1:0]        dup_count, dup_count_next;
  logic [DUP_THR_W-1:0]    dup_thr;

  logic                    skid_valid;
  logic [OUT_DATA_W-1:0]   skid_data;

  logic                    in_acc, out_free;
  logic                    loss_done;
  logic [WINDOW_WIDTH-1:0] win_inc, win_dbl, win_half;
  logic [WINDOW_WIDTH:0]   inflate_sum;
  logic [WINDOW_WIDTH-1:0] win_inflate;
  logic [OUT_DATA_W-1:0]   result_word;

  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !skid_valid;
  assign cfg_ready = 1'b1;

  // Saturating window arithmetic
  assign loss_done   = (s_tdata == '0) || s_tdata[LOSS_W-1];
  assign win_inc     = (window == WinMax) ? WinMax : window + WinOne;
  assign win_dbl     = window[WINDOW_WIDTH-1] ? WinMax : {window[WINDOW_WIDTH-2:0], 1'b0};
  assign win_half    = window >> 1;
  assign inflate_sum = {1'b0, win_half} + (WINDOW_WIDTH+1)'(RECOVERY_INFLATE);
  assign win_inflate = inflate_sum[WINDOW_WIDTH] ? WinMax : inflate_sum[WINDOW_WIDTH-1:0];

  // Next state for one event
  always_comb begin
    phase_next     = phase;
    window_next    = window;
    threshold_next = threshold;
    dup_count_next = dup_count;
    unique case (s_tuser)
      KIND_DUP_ACK: begin
        dup_count_next = (dup_count == DupMax) ? DupMax : dup_count + DUP_W'(1);
        if (phase == PH_RECOVER) begin
          window_next = win_inc;
        end else if (dup_count_next == DUP_W'(dup_thr)) begin
          threshold_next = win_half;
          window_next    = win_inflate;
          phase_next     = PH_RECOVER;
        end
      end
      KIND_NEW_ACK: begin
        dup_count_next = '0;
        unique case (phase)
          PH_RECOVER: begin
            if (loss_done) begin
              window_next = threshold;
              phase_next  = PH_AVOID;
            end else begin
              window_next = win_inc;
            end
          end
          PH_SLOW: begin
            window_next = win_dbl;
            if (win_dbl >= threshold) phase_next = PH_AVOID;
          end
          default: window_next = win_inc;
        endcase
      end
      KIND_TIMEOUT: begin
        threshold_next = win_half;
        window_next    = WinOne;
        phase_next     = PH_SLOW;
      end
      default: ;
    endcase
  end

  assign result_word = {6'b0, phase_next, FIELD_W'(threshold_next), FIELD_W'(window_next)};

  // Advance state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SLOW;
      window    <= WinOne;
      threshold <= InitThr;
      dup_count <= '0;
    end else if (in_acc) begin
      phase     <= phase_next;
      window    <= window_next;
      threshold <= threshold_next;
      dup_count <= dup_count_next;
    end
  end

  // Trigger register
  always_ff @(posedge clk) begin
    if (rst) begin
      dup_thr <= DUP_THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dup_thr <= cfg_data;
    end
  end

  // Output register and skid stage: control
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= in_acc;
      end else begin
        m_tvalid <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid <= 1'b1;
    end
  end

  // Output register and skid stage: payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        m_tdata <= skid_data;
        if (in_acc) skid_data <= result_word;
      end else if (in_acc) begin
        m_tdata <= result_word;
      end
    end else if (in_acc) begin
      skid_data <= result_word;
    end
  end

  // A timeout always restarts slow start from a window of one
  a_timeout_restart: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_tuser == KIND_TIMEOUT |=> window == WinOne && phase == PH_SLOW)
    else $error("timeout did not restart slow start");

  // Fast recovery never shrinks the window below the threshold
  a_recover_window: assert property (@(posedge clk) disable iff (rst)
    phase == PH_RECOVER |-> window >= threshold)
    else $error("window below threshold in fast recovery");

  // A new ACK clears the duplicate count
  a_new_ack_clears: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_tuser == KIND_NEW_ACK |=> dup_count == '0)
    else $error("duplicate count not cleared by new ACK");

  // The skid stage only fills behind a held result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid word without an output word");

endmodule
